[src/glyph_cell_grid_allocator_macros.svh]
// Assertion macros shared by the glyph cell allocator RTL.
`ifndef GLYPH_CELL_GRID_ALLOCATOR_MACROS_SVH
`define GLYPH_CELL_GRID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GCGA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GCGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gcga_pkg.sv]
// Types, codes and constants of the glyph cell allocator.
`default_nettype none

package gcga_pkg;

   localparam int CELL_COUNT_DEF = 1024;
   localparam int DIM_W          = 13;
   localparam int POS_W          = 12;
   localparam int GLYPH_W        = 16;
   localparam int SEL_W          = 10;
   localparam int USE_W          = 3;
   localparam int CSR_IDX_W      = 3;

   localparam logic [USE_W-1:0] USE_COUNT_MAX = 3'd7;

   localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 13'd512;
   localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 13'd512;
   localparam logic [DIM_W-1:0] CELL_WIDTH_RST   = 13'd16;
   localparam logic [DIM_W-1:0] CELL_HEIGHT_RST  = 13'd16;
   localparam logic [USE_W-1:0] THRESHOLD_RST    = 3'd5;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_RENDER = 2'd1,
      CMD_INVAL  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_NEW       = 3'd0,
      STAT_REUSE     = 3'd1,
      STAT_EVICT     = 3'd2,
      STAT_TOO_LARGE = 3'd3,
      STAT_DONE      = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATLAS_WIDTH  = 3'd0,
      CSR_ATLAS_HEIGHT = 3'd1,
      CSR_CELL_WIDTH   = 3'd2,
      CSR_CELL_HEIGHT  = 3'd3,
      CSR_THRESHOLD    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEW,
      ST_WALK,
      ST_LAP,
      ST_PLACE,
      ST_RENDER,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PL_IDLE,
      PL_COLS,
      PL_COLS_WAIT,
      PL_SPLIT,
      PL_SPLIT_WAIT,
      PL_MUL,
      PL_DONE
   } place_state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [GLYPH_W-1:0] glyph_id;
      logic [DIM_W-1:0]   glyph_width;
      logic [DIM_W-1:0]   glyph_height;
      logic [SEL_W-1:0]   cell_select;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [SEL_W-1:0]   cell_index;
      logic [POS_W-1:0]   cell_x;
      logic [POS_W-1:0]   cell_y;
      logic [GLYPH_W-1:0] evicted_glyph;
      logic               flush_request;
   } rsp_type;

   typedef struct packed {
      logic               occupied;
      logic [USE_W-1:0]   use_count;
      logic [GLYPH_W-1:0] glyph;
   } cell_type;

   typedef struct packed {
      logic [DIM_W-1:0] atlas_width;
      logic [DIM_W-1:0] cell_width;
      logic [DIM_W-1:0] cell_height;
   } geom_type;

   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } place_rsp_type;

endpackage

`default_nettype wire

[src/gcga_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gcga_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/gcga_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module gcga_div #(
   parameter int W = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [W:0]       shifted;
   logic [W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it did not go negative
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

[src/gcga_place.sv]
// Cell index to pixel position, from the current grid geometry.
`default_nettype none

module gcga_place #(
   parameter int CELL_COUNT = gcga_pkg::CELL_COUNT_DEF,
   parameter int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [IDX_W-1:0]        idx,
   input  gcga_pkg::geom_type      geom,
   output gcga_pkg::place_rsp_type rsp
);

   import gcga_pkg::*;

   localparam int CNT_W = $clog2(CELL_COUNT + 1);
   localparam int DIV_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;

   place_state_type  pst_ff, pst_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DIV_W-1:0] cols_ff, cols_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] x_ff, x_in;
   logic [POS_W-1:0] y_ff, y_in;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic [DIV_W-1:0] div_rem;

   gcga_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      pst_in       = pst_ff;
      idx_in       = idx_ff;
      cols_in      = cols_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'(geom.atlas_width);
      div_divisor  = DIV_W'(geom.cell_width);
      case (pst_ff)
         PL_IDLE: begin
            if (start) begin
               idx_in = idx;
               pst_in = PL_COLS;
            end
         end
         PL_COLS: begin
            // zero-width cells lay out in a single row of full length
            if (geom.cell_width == '0) begin
               cols_in = DIV_W'(CELL_COUNT);
               pst_in  = PL_SPLIT;
            end else begin
               div_start = 1'b1;
               pst_in    = PL_COLS_WAIT;
            end
         end
         PL_COLS_WAIT: begin
            if (div_done) begin
               cols_in = (div_quot == '0) ? DIV_W'(1) : div_quot;
               pst_in  = PL_SPLIT;
            end
         end
         PL_SPLIT: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(idx_ff);
            div_divisor  = cols_ff;
            pst_in       = PL_SPLIT_WAIT;
         end
         PL_SPLIT_WAIT: begin
            if (div_done) begin
               quot_in = div_quot;
               rem_in  = div_rem;
               pst_in  = PL_MUL;
            end
         end
         PL_MUL: begin
            x_in   = POS_W'(rem_ff * DIV_W'(geom.cell_width));
            y_in   = POS_W'(quot_ff * DIV_W'(geom.cell_height));
            pst_in = PL_DONE;
         end
         PL_DONE: begin
            pst_in = PL_IDLE;
         end
         default: begin
            pst_in = PL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= PL_IDLE;
      end else begin
         pst_ff <= pst_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cols_ff <= cols_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign rsp.done = (pst_ff == PL_DONE);
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;

endmodule

`default_nettype wire

[src/glyph_cell_grid_allocator.sv]
// Glyph cell allocator top level: control sequencer around the cell memory.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------
//   req     | in        | req_valid / req_ready | req_data  (req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (rsp_type)
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item is worked on at a time; the result sits in an output register,
// so the next item is taken while it waits. Invalidate-all clears one cell
// memory row a cycle. A reused cell is searched one ring cell a cycle, and
// its position then comes from the serial divider, of width DW = 13 at the
// default cell count. No clearing pass after reset: the contents of cells
// beyond the fill count are never used. A stalled rsp only holds the
// sequencer in its final state.
`default_nettype none
`include "glyph_cell_grid_allocator_macros.svh"

module glyph_cell_grid_allocator #(
   parameter int MAX_CELLS = gcga_pkg::CELL_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  gcga_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output gcga_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [gcga_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcga_pkg::DIM_W-1:0]       csr_wdata
);

   import gcga_pkg::*;

   localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CNT_W  = $clog2(MAX_CELLS + 1);
   localparam int CMP_W  = (CNT_W > SEL_W) ? CNT_W : SEL_W;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [CNT_W-1:0]   cells_made_ff, cells_made_in;
   logic [ADDR_W-1:0]  oldest_ff, oldest_in;
   logic [POS_W-1:0]   next_x_ff, next_x_in;
   logic [POS_W-1:0]   next_y_ff, next_y_in;
   logic               full_ff, full_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in;
   logic [ADDR_W-1:0]  ahead_ff, ahead_in;
   logic [CNT_W-1:0]   visits_ff, visits_in;
   cell_type           start_cell_ff, start_cell_in;
   logic [ADDR_W-1:0]  chosen_ff, chosen_in;
   logic               had_ff, had_in;
   logic [GLYPH_W-1:0] ev_ff, ev_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [DIM_W-1:0]   aw_ff, aw_in;
   logic [DIM_W-1:0]   ah_ff, ah_in;
   logic [DIM_W-1:0]   cw_ff, cw_in;
   logic [DIM_W-1:0]   ch_ff, ch_in;
   logic [USE_W-1:0]   thr_ff, thr_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   cell_type           ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   cell_type           ram_rdata;

   logic               place_start;
   logic [ADDR_W-1:0]  place_idx;
   geom_type           geom;
   place_rsp_type      place_rsp;

   logic               too_large;
   logic               first_cell;
   logic               at_max;
   logic [POS_W+1:0]   x_step;
   logic [POS_W+2:0]   x_end;
   logic [POS_W+1:0]   y_step;
   logic [POS_W+2:0]   y_end;
   logic               row_wrap;
   logic               grid_over;
   logic [POS_W-1:0]   new_x;
   logic [POS_W-1:0]   new_y;
   logic               pick;
   logic               last_visit;

   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] a,
                                                    input logic [CNT_W-1:0]  n);
      logic [ADDR_W-1:0] r;
      if (CNT_W'(a) == n - CNT_W'(1)) begin
         r = '0;
      end else begin
         r = a + ADDR_W'(1);
      end
      return r;
   endfunction

   gcga_ram #(
      .WIDTH  ($bits(cell_type)),
      .DEPTH  (MAX_CELLS),
      .ADDR_W (ADDR_W)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign geom.atlas_width = aw_ff;
   assign geom.cell_width  = cw_ff;
   assign geom.cell_height = ch_ff;

   gcga_place #(
      .CELL_COUNT (MAX_CELLS),
      .IDX_W      (ADDR_W)
   ) u_place (
      .clock (clock),
      .reset (reset),
      .start (place_start),
      .idx   (place_idx),
      .geom  (geom),
      .rsp   (place_rsp)
   );

   // next row-major position after the most recent cell, plus size, fill and walk flags
   always_comb begin
      too_large  = (req_data.glyph_width > cw_ff) || (req_data.glyph_height > ch_ff);
      first_cell = (cells_made_ff == '0);
      at_max     = (cells_made_ff == CNT_W'(MAX_CELLS));
      x_step     = (POS_W+2)'(next_x_ff) + (POS_W+2)'(cw_ff);
      x_end      = (POS_W+3)'(x_step) + (POS_W+3)'(cw_ff);
      y_step     = (POS_W+2)'(next_y_ff) + (POS_W+2)'(ch_ff);
      y_end      = (POS_W+3)'(y_step) + (POS_W+3)'(ch_ff);
      row_wrap   = x_end > (POS_W+3)'(aw_ff);
      grid_over  = y_end > (POS_W+3)'(ah_ff);
      if (first_cell) begin
         new_x = '0;
         new_y = '0;
      end else if (row_wrap) begin
         new_x = '0;
         new_y = POS_W'(y_step);
      end else begin
         new_x = POS_W'(x_step);
         new_y = next_y_ff;
      end
      pick       = !ram_rdata.occupied || (ram_rdata.use_count < thr_ff);
      last_visit = (visits_ff == cells_made_ff - CNT_W'(1));
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cells_made_in = cells_made_ff;
      oldest_in     = oldest_ff;
      next_x_in     = next_x_ff;
      next_y_in     = next_y_ff;
      full_in       = full_ff;
      cur_in        = cur_ff;
      ahead_in      = ahead_ff;
      visits_in     = visits_ff;
      start_cell_in = start_cell_ff;
      chosen_in     = chosen_ff;
      had_in        = had_ff;
      ev_in         = ev_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = ahead_ff;
      place_start   = 1'b0;
      place_idx     = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            case (req_data.cmd)
               CMD_RENDER: ram_raddr = ADDR_W'(req_data.cell_select);
               CMD_INVAL:  ram_raddr = '0;
               default:    ram_raddr = oldest_ff;
            endcase
            if (req_valid) begin
               item_in          = req_data;
               res_in           = '0;
               res_in.status    = STAT_DONE;
               cur_in           = oldest_ff;
               ahead_in         = ring_next(oldest_ff, cells_made_ff);
               visits_in        = '0;
               case (req_data.cmd)
                  CMD_ADD: begin
                     if (too_large) begin
                        res_in.status = STAT_TOO_LARGE;
                        state_in      = ST_DONE;
                     end else if (full_ff) begin
                        state_in = ST_WALK;
                     end else begin
                        state_in = ST_NEW;
                     end
                  end
                  CMD_RENDER: begin
                     if (CMP_W'(req_data.cell_select) < CMP_W'(cells_made_ff)) begin
                        state_in = ST_RENDER;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_INVAL: begin
                     res_in.flush_request = 1'b1;
                     cur_in               = '0;
                     ahead_in             = ADDR_W'(1);
                     if (first_cell) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_NEW: begin
            if (at_max || (!first_cell && row_wrap && grid_over)) begin
               // grid is full: fall into the ring walk from the oldest cell
               full_in   = 1'b1;
               ram_raddr = oldest_ff;
               cur_in    = oldest_ff;
               ahead_in  = ring_next(oldest_ff, cells_made_ff);
               visits_in = '0;
               state_in  = ST_WALK;
            end else begin
               ram_we              = 1'b1;
               ram_waddr           = ADDR_W'(cells_made_ff);
               ram_wdata.occupied  = 1'b1;
               ram_wdata.use_count = '0;
               ram_wdata.glyph     = item_ff.glyph_id;
               next_x_in           = new_x;
               next_y_in           = new_y;
               cells_made_in       = cells_made_ff + CNT_W'(1);
               res_in.status       = STAT_NEW;
               res_in.cell_index   = SEL_W'(cells_made_ff);
               res_in.cell_x       = new_x;
               res_in.cell_y       = new_y;
               state_in            = ST_DONE;
            end
         end
         ST_WALK: begin
            if (visits_ff == '0) begin
               start_cell_in = ram_rdata;
            end
            ram_we              = 1'b1;
            ram_waddr           = cur_ff;
            ram_wdata.use_count = '0;
            if (pick) begin
               ram_wdata.occupied = 1'b1;
               ram_wdata.glyph    = item_ff.glyph_id;
               oldest_in          = ring_next(cur_ff, cells_made_ff);
               chosen_in          = cur_ff;
               had_in             = ram_rdata.occupied;
               ev_in              = ram_rdata.glyph;
               place_start        = 1'b1;
               place_idx          = cur_ff;
               state_in           = ST_PLACE;
            end else if (last_visit) begin
               state_in = ST_LAP;
            end else begin
               cur_in    = ahead_ff;
               ahead_in  = ring_next(ahead_ff, cells_made_ff);
               visits_in = visits_ff + CNT_W'(1);
            end
         end
         ST_LAP: begin
            // full lap without a candidate: take the cell the lap started at
            ram_we              = 1'b1;
            ram_waddr           = oldest_ff;
            ram_wdata.occupied  = 1'b1;
            ram_wdata.use_count = '0;
            ram_wdata.glyph     = item_ff.glyph_id;
            chosen_in           = oldest_ff;
            had_in              = start_cell_ff.occupied;
            ev_in               = start_cell_ff.glyph;
            oldest_in           = ring_next(oldest_ff, cells_made_ff);
            place_start         = 1'b1;
            place_idx           = oldest_ff;
            state_in            = ST_PLACE;
         end
         ST_PLACE: begin
            if (place_rsp.done) begin
               res_in.status        = had_ff ? STAT_EVICT : STAT_REUSE;
               res_in.cell_index    = SEL_W'(chosen_ff);
               res_in.cell_x        = place_rsp.x;
               res_in.cell_y        = place_rsp.y;
               res_in.evicted_glyph = had_ff ? ev_ff : '0;
               res_in.flush_request = had_ff;
               state_in             = ST_DONE;
            end
         end
         ST_RENDER: begin
            ram_waddr = ADDR_W'(item_ff.cell_select);
            if (ram_rdata.use_count < USE_COUNT_MAX) begin
               ram_we              = 1'b1;
               ram_wdata.use_count = ram_rdata.use_count + USE_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            // read one cell ahead while clearing the one just read
            ram_we             = 1'b1;
            ram_waddr          = cur_ff;
            ram_wdata.occupied = 1'b0;
            if (CNT_W'(cur_ff) == cells_made_ff - CNT_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               cur_in   = ahead_ff;
               ahead_in = ahead_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      aw_in  = aw_ff;
      ah_in  = ah_ff;
      cw_in  = cw_ff;
      ch_in  = ch_ff;
      thr_in = thr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  aw_in  = csr_wdata;
            CSR_ATLAS_HEIGHT: ah_in  = csr_wdata;
            CSR_CELL_WIDTH:   cw_in  = csr_wdata;
            CSR_CELL_HEIGHT:  ch_in  = csr_wdata;
            CSR_THRESHOLD:    thr_in = csr_wdata[USE_W-1:0];
            default:          aw_in  = aw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cells_made_ff <= '0;
         oldest_ff     <= '0;
         next_x_ff     <= '0;
         next_y_ff     <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         aw_ff         <= ATLAS_WIDTH_RST;
         ah_ff         <= ATLAS_HEIGHT_RST;
         cw_ff         <= CELL_WIDTH_RST;
         ch_ff         <= CELL_HEIGHT_RST;
         thr_ff        <= THRESHOLD_RST;
      end else begin
         state_ff      <= state_in;
         cells_made_ff <= cells_made_in;
         oldest_ff     <= oldest_in;
         next_x_ff     <= next_x_in;
         next_y_ff     <= next_y_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
         aw_ff         <= aw_in;
         ah_ff         <= ah_in;
         cw_ff         <= cw_in;
         ch_ff         <= ch_in;
         thr_ff        <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      cur_ff        <= cur_in;
      ahead_ff      <= ahead_in;
      visits_ff     <= visits_in;
      start_cell_ff <= start_cell_in;
      chosen_ff     <= chosen_in;
      had_ff        <= had_in;
      ev_ff         <= ev_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GCGA_ASSERT_IMP(a_walk_bound, clock, reset, (state_ff == ST_WALK), (visits_ff < cells_made_ff), "ring walk ran past the fill count")
   `GCGA_ASSERT_IMP(a_oldest_bound, clock, reset, full_ff, (CNT_W'(oldest_ff) < cells_made_ff), "oldest cell outside the ring")
   `GCGA_ASSERT_IMP(a_write_bound, clock, reset, ram_we, ((CNT_W'(ram_waddr) < cells_made_ff) || (state_ff == ST_NEW)), "cell write beyond the made cells")
   `GCGA_ASSERT_NEXT(a_result_out, clock, reset, ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)), (rsp_valid_ff && (state_ff == ST_IDLE)), "finished item not presented")

endmodule

`default_nettype wire
